// ----- rtl/mscr_pkg.sv -----
`default_nettype none

package mscr_pkg;

	localparam int KEY_W = 32;
	localparam int SCORE_W = 32;
	localparam int STATUS_W = 3;
	localparam int CAP_W = 5;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_ACCESS = 1'b1;

	localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/min_score_replacement_table.sv -----
// Min-score replacement table. A request is taken at a clock edge where start
// is high and busy is low; its result appears on status, score_read,
// victim_key and victim_score for exactly one cycle with done high, and must
// be captured then since the block cannot be stalled. Each request sweeps the
// filled entries through the single read port of the entry memory, comparing
// keys and tracking the minimum score on the way, then commits in its decide
// state. The next request may be accepted in the cycle where done is high.
// Writing the capacity register empties the table; it must only be written
// while the block is idle.
`default_nettype none

module min_score_replacement_table
	import mscr_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       opcode,
	input  wire logic signed [KEY_W-1:0]    key,
	input  wire logic signed [SCORE_W-1:0]  new_score,
	input  wire logic                       cfg_we,
	input  wire logic [CAP_W-1:0]           cfg_wdata,
	output logic                            done,
	output logic [STATUS_W-1:0]             status,
	output logic signed [SCORE_W-1:0]       score_read,
	output logic signed [KEY_W-1:0]         victim_key,
	output logic signed [SCORE_W-1:0]       victim_score
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int ENT_W = KEY_W + SCORE_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	logic [1:0]             state_q;
	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   found_q;
	logic                   done_q;

	logic                   opcode_q;
	logic [KEY_W-1:0]       key_q;
	logic [SCORE_W-1:0]     score_q;
	logic [IDX_W-1:0]       idx_s1;
	logic [IDX_W-1:0]       found_idx_q;
	logic [SCORE_W-1:0]     found_score_q;
	logic [IDX_W-1:0]       min_idx_q;
	logic [KEY_W-1:0]       min_key_q;
	logic signed [SCORE_W-1:0] min_score_q;

	logic [STATUS_W-1:0]    status_q;
	logic [SCORE_W-1:0]     score_read_q;
	logic [KEY_W-1:0]       victim_key_q;
	logic [SCORE_W-1:0]     victim_score_q;

	logic                   accept;
	logic                   issue;
	logic                   last_cmp;
	logic                   cmp_vld_s1;
	logic [CMP_W-1:0]       cap_wide;
	logic [CMP_W-1:0]       cap_eff;
	logic                   room;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_rdata;
	logic [KEY_W-1:0]       rd_key;
	logic signed [SCORE_W-1:0] rd_score;
	logic                   key_hit;
	logic                   new_min;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	assign issue = (state_q == S_SWEEP) && (rd_idx_q != fill_q);
	// With no read issued this cycle, the last entry's data, if any, is being compared.
	assign last_cmp = (state_q == S_SWEEP) && (rd_idx_q == fill_q);

	// Capacity of zero acts as one; anything above the table depth saturates.
	always_comb begin
		cap_wide = CMP_W'(cap_q);
		if (cap_wide == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_wide > CMP_W'(TABLE_DEPTH)) begin
			cap_eff = CMP_W'(TABLE_DEPTH);
		end else begin
			cap_eff = cap_wide;
		end
	end

	assign room = CMP_W'(fill_q) < cap_eff;

	assign rd_key = ram_rdata[ENT_W-1:SCORE_W];
	assign rd_score = $signed(ram_rdata[SCORE_W-1:0]);
	assign key_hit = cmp_vld_s1 && !found_q && (rd_key == key_q);
	// Strict compare keeps the lowest index on a tie.
	assign new_min = cmp_vld_s1 && ((idx_s1 == '0) || (rd_score < min_score_q));

	assign ram_we = (state_q == S_DECIDE) && (opcode_q == OP_ADD);

	always_comb begin
		if (found_q) begin
			ram_waddr = found_idx_q;
		end else if (room) begin
			ram_waddr = fill_q[IDX_W-1:0];
		end else begin
			ram_waddr = min_idx_q;
		end
	end

	mscr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({key_q, score_q}),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= CAP_RESET;
			fill_q <= '0;
			rd_idx_q <= '0;
			found_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			cmp_vld_s1 <= issue;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
				fill_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SWEEP;
						rd_idx_q <= '0;
						found_q <= 1'b0;
					end
				end
				S_SWEEP: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (key_hit) begin
						found_q <= 1'b1;
					end
					if (last_cmp) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					if ((opcode_q == OP_ADD) && !found_q && room) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= opcode;
			key_q <= key;
			score_q <= new_score;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (key_hit) begin
			found_idx_q <= idx_s1;
			found_score_q <= rd_score;
		end
		if (new_min) begin
			min_idx_q <= idx_s1;
			min_key_q <= rd_key;
			min_score_q <= rd_score;
		end
		if (state_q == S_DECIDE) begin
			score_read_q <= '0;
			victim_key_q <= '0;
			victim_score_q <= '0;
			if (opcode_q == OP_ACCESS) begin
				if (found_q) begin
					status_q <= ST_HIT;
					score_read_q <= found_score_q;
				end else begin
					status_q <= ST_MISS;
				end
			end else if (found_q) begin
				status_q <= ST_UPDATED;
			end else if (room) begin
				status_q <= ST_INSERTED;
			end else begin
				status_q <= ST_EVICTED;
				victim_key_q <= min_key_q;
				victim_score_q <= min_score_q;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign score_read = $signed(score_read_q);
	assign victim_key = $signed(victim_key_q);
	assign victim_score = $signed(victim_score_q);

endmodule

`default_nettype wire

// ----- rtl/mscr_ram.sv -----
`default_nettype none

module mscr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [ADDR_W-1:0]        waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [ADDR_W-1:0]        raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
